// ===== hw/rtl/hwu_pkg.sv =====
// ----------------------------------------------------------------------------
// hwu_pkg: shared types and arithmetic for the Hebbian weight update core
// Signed Q16.16 types, constants, saturating helpers and the pipeline step
// functions used by the multiply stages.
// ----------------------------------------------------------------------------
package hwu_pkg;

	typedef logic signed [31:0] q_t;

	localparam int NLANE = 3;

	localparam q_t Q_ZERO          = 32'sd0;
	localparam q_t Q_ONE           = 32'sd65536;
	localparam q_t Q_TWO           = 32'sd131072;
	localparam q_t Q_FOUR          = 32'sd262144;
	localparam q_t Q_FIVE          = 32'sd327680;
	localparam q_t Q_NEG_FIVE      = -32'sd327680;
	localparam q_t Q_HUNDREDTH     = 32'sd655;
	localparam q_t Q_NEG_HUNDREDTH = -32'sd655;
	localparam q_t Q_MAX           = 32'sh7FFF_FFFF;
	localparam q_t Q_MIN           = 32'sh8000_0000;

	// Rule and synapse kind, coded as {use_old_rule, inhibitory}
	localparam logic [1:0] CASE_NEW_EXC = 2'b00;
	localparam logic [1:0] CASE_NEW_INH = 2'b01;
	localparam logic [1:0] CASE_OLD_EXC = 2'b10;
	localparam logic [1:0] CASE_OLD_INH = 2'b11;

	// One multiply lane: running product and the factors still to apply
	typedef struct packed {
		q_t         acc;
		q_t [3:0]   fac;
	} lane_acc_t;

	typedef struct packed {
		logic signed [63:0] prod;
		q_t [3:0]           fac;
	} lane_prod_t;

	typedef struct packed {
		logic                   old_sel;
		logic                   inh;
		q_t                     w;
		lane_acc_t [NLANE-1:0]  lane;
	} acc_item_t;

	typedef struct packed {
		logic                   old_sel;
		logic                   inh;
		q_t                     w;
		lane_prod_t [NLANE-1:0] lane;
	} prod_item_t;

	// Saturating add
	function automatic q_t qadd(q_t a, q_t b);
		logic signed [32:0] s;
		q_t                 r;
		s = $signed({a[31], a}) + $signed({b[31], b});
		if (s[32] != s[31]) begin
			r = s[32] ? Q_MIN : Q_MAX;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	// Saturating subtract
	function automatic q_t qsub(q_t a, q_t b);
		logic signed [32:0] s;
		q_t                 r;
		s = $signed({a[31], a}) - $signed({b[31], b});
		if (s[32] != s[31]) begin
			r = s[32] ? Q_MIN : Q_MAX;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	// Saturating negate
	function automatic q_t qneg(q_t a);
		q_t r;
		if (a == Q_MIN) begin
			r = Q_MAX;
		end else begin
			r = q_t'(32'd0 - a);
		end
		return r;
	endfunction

	// Scale a full product by 2^-16, round half away from zero, saturate
	function automatic q_t qround(logic signed [63:0] p);
		logic [63:0] mag;
		logic [63:0] sum;
		logic [47:0] q;
		q_t          r;
		mag = p[63] ? 64'(-p) : 64'(p);
		sum = mag + 64'd32768;
		q   = sum[63:16];
		if (p[63]) begin
			r = (q > 48'h0000_8000_0000) ? Q_MIN : q_t'(32'd0 - q[31:0]);
		end else begin
			r = (q > 48'h0000_7FFF_FFFF) ? Q_MAX : q_t'(q[31:0]);
		end
		return r;
	endfunction

	// Multiply each lane's running value by its next factor
	function automatic prod_item_t mul_step(acc_item_t x);
		prod_item_t y;
		y.old_sel = x.old_sel;
		y.inh     = x.inh;
		y.w       = x.w;
		for (int i = 0; i < NLANE; i++) begin
			y.lane[i].prod = $signed(x.lane[i].acc) * $signed(x.lane[i].fac[0]);
			y.lane[i].fac  = {Q_ZERO, x.lane[i].fac[3:1]};
		end
		return y;
	endfunction

	// Round each lane's product back to Q16.16
	function automatic acc_item_t round_step(prod_item_t x);
		acc_item_t y;
		y.old_sel = x.old_sel;
		y.inh     = x.inh;
		y.w       = x.w;
		for (int i = 0; i < NLANE; i++) begin
			y.lane[i].acc = qround(x.lane[i].prod);
			y.lane[i].fac = x.lane[i].fac;
		end
		return y;
	endfunction

endpackage

// ===== hw/rtl/hebbian_weight_update_core.sv =====
// ----------------------------------------------------------------------------
// hebbian_weight_update_core: pipelined synapse weight update
// Clamps the old weight, forms the rule's learning terms in three multiply
// lanes, sums them with saturation and applies the rule's sign and floor.
// ----------------------------------------------------------------------------
// The core takes one synapse request per clock when the output side is not
// stalled and returns the new weight for each request. Four stages prepare
// the operands, eight stages run three parallel lanes of four chained 32x32
// Q16.16 multiplies (each a product stage and a round/saturate stage), and
// four stages add the terms and apply the rule's floor or sign. Throughput
// is one request per cycle, set by the fully pipelined multiplier lanes; a
// stall on the output holds each occupied stage that has no empty stage
// after it, and the input backs up only once the pipeline is full.
module hebbian_weight_update_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  hwu_pkg::q_t  old_weight,
	input  hwu_pkg::q_t  weight_limit,
	input  hwu_pkg::q_t  pre_act,
	input  hwu_pkg::q_t  post_act,
	input  hwu_pkg::q_t  hebb_lr,
	input  hwu_pkg::q_t  presyn_rate,
	input  hwu_pkg::q_t  postsyn_rate,
	input  logic         use_old_rule,
	output logic         out_valid,
	input  logic         out_ready,
	output hwu_pkg::q_t  new_weight
);

	localparam int NSTG = 16;

	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] rdy;

	// Stage 1: raised limit and its negation
	hwu_pkg::q_t w_s1, mx_s1, nmx_s1, ai_s1, ao_s1, h_s1, pr_s1, po_s1;
	logic        old_s1;
	// Stage 2: clamped weight magnitude and synapse kind
	hwu_pkg::q_t w_s2, mx_s2, ai_s2, ao_s2, h_s2, pr_s2, po_s2;
	logic        old_s2, inh_s2;
	// Stage 3: differences and offsets
	hwu_pkg::q_t w_s3, mx_s3, top_a_s3, mx2_s3, w4_s3, mxw_s3;
	hwu_pkg::q_t ai_s3, ao_s3, ai1_s3, ao1_s3, oneao_s3, h_s3, nh_s3, pr_s3, po_s3;
	logic        old_s3, inh_s3;
	// Stages 4..12: lane factors and multiply chain
	hwu_pkg::acc_item_t  it_s4, it_s6, it_s8, it_s10, it_s12;
	hwu_pkg::prod_item_t p_s5, p_s7, p_s9, p_s11;
	hwu_pkg::acc_item_t  it4_d;
	// Stages 13..16: term sums and final rule
	hwu_pkg::q_t d1_s13, t3_s13, w_s13, d_s14, w_s14, sum_s15, res_s16;
	logic        old_s13, inh_s13, old_s14, inh_s14, old_s15, inh_s15;
	hwu_pkg::q_t res_d;

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		rdy[NSTG+1] = out_ready;
		for (int k = NSTG; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_ready   = rdy[1];
	assign out_valid  = vld_q[NSTG];
	assign new_weight = res_s16;

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Build the four factors of each lane for the selected rule
	always_comb begin
		hwu_pkg::q_t top;
		hwu_pkg::q_t top2;
		top  = (top_a_s3 > mx_s3) ? mx_s3 : top_a_s3;
		top2 = (top_a_s3 > mx_s3) ? mx2_s3 : w4_s3;
		it4_d.old_sel = old_s3;
		it4_d.inh     = inh_s3;
		it4_d.w       = w_s3;
		it4_d.lane[0].acc = hwu_pkg::Q_ONE;
		it4_d.lane[1].acc = hwu_pkg::Q_ONE;
		it4_d.lane[2].acc = hwu_pkg::Q_ZERO;
		it4_d.lane[2].fac = '0;
		case ({old_s3, inh_s3})
			hwu_pkg::CASE_OLD_EXC: begin
				it4_d.lane[0].fac = {ao_s3, ai_s3, mxw_s3, h_s3};
				it4_d.lane[1].fac = {ao1_s3, ai_s3, w_s3, pr_s3};
				it4_d.lane[2].acc = hwu_pkg::Q_ONE;
				it4_d.lane[2].fac = {ao_s3, ai1_s3, w_s3, po_s3};
			end
			hwu_pkg::CASE_OLD_INH: begin
				it4_d.lane[0].fac = {oneao_s3, ai_s3, mxw_s3, h_s3};
				it4_d.lane[1].acc = hwu_pkg::Q_NEG_FIVE;
				it4_d.lane[1].fac = {ao_s3, ai_s3, w_s3, h_s3};
			end
			hwu_pkg::CASE_NEW_EXC: begin
				it4_d.lane[0].fac = {ao_s3, ai_s3, mxw_s3, h_s3};
				it4_d.lane[1].fac = {ao1_s3, ai_s3, top, pr_s3};
			end
			default: begin
				it4_d.lane[0].fac = {oneao_s3, ai_s3, mxw_s3, pr_s3};
				it4_d.lane[1].fac = {ao_s3, ai_s3, top2, nh_s3};
			end
		endcase
	end

	// Apply the rule's floor or sign to the final sum
	always_comb begin
		case ({old_s15, inh_s15})
			hwu_pkg::CASE_OLD_EXC: begin
				res_d = (!sum_s15[31] && sum_s15 != hwu_pkg::Q_ZERO) ?
					sum_s15 : hwu_pkg::Q_HUNDREDTH;
			end
			hwu_pkg::CASE_OLD_INH: begin
				res_d = (!sum_s15[31] && sum_s15 != hwu_pkg::Q_ZERO) ?
					hwu_pkg::qneg(sum_s15) : hwu_pkg::Q_NEG_HUNDREDTH;
			end
			hwu_pkg::CASE_NEW_EXC: begin
				res_d = sum_s15;
			end
			default: begin
				res_d = hwu_pkg::qneg(sum_s15);
			end
		endcase
	end

	// Pipeline data registers
	always_ff @(posedge clk) begin
		// Raise the limit to at least 5.0
		if (rdy[1]) begin
			w_s1   <= old_weight;
			mx_s1  <= (weight_limit < hwu_pkg::Q_FIVE) ? hwu_pkg::Q_FIVE : weight_limit;
			nmx_s1 <= (weight_limit < hwu_pkg::Q_FIVE) ? hwu_pkg::Q_NEG_FIVE :
				hwu_pkg::q_t'(32'd0 - weight_limit);
			ai_s1  <= pre_act;
			ao_s1  <= post_act;
			h_s1   <= hebb_lr;
			pr_s1  <= presyn_rate;
			po_s1  <= postsyn_rate;
			old_s1 <= use_old_rule;
		end
		// Clamp the weight and take its magnitude
		if (rdy[2]) begin
			if (w_s1 > mx_s1) begin
				w_s2   <= mx_s1;
				inh_s2 <= 1'b0;
			end else if (w_s1 < nmx_s1) begin
				w_s2   <= mx_s1;
				inh_s2 <= 1'b1;
			end else if (w_s1[31]) begin
				w_s2   <= hwu_pkg::q_t'(32'd0 - w_s1);
				inh_s2 <= 1'b1;
			end else begin
				w_s2   <= w_s1;
				inh_s2 <= 1'b0;
			end
			mx_s2  <= mx_s1;
			ai_s2  <= ai_s1;
			ao_s2  <= ao_s1;
			h_s2   <= h_s1;
			pr_s2  <= pr_s1;
			po_s2  <= po_s1;
			old_s2 <= old_s1;
		end
		// Form differences and the top-weight candidates
		if (rdy[3]) begin
			w_s3     <= w_s2;
			mx_s3    <= mx_s2;
			top_a_s3 <= hwu_pkg::qadd(w_s2, hwu_pkg::Q_TWO);
			mx2_s3   <= hwu_pkg::qadd(mx_s2, hwu_pkg::Q_TWO);
			w4_s3    <= hwu_pkg::qadd(w_s2, hwu_pkg::Q_FOUR);
			mxw_s3   <= hwu_pkg::qsub(mx_s2, w_s2);
			ai_s3    <= ai_s2;
			ao_s3    <= ao_s2;
			ai1_s3   <= hwu_pkg::qsub(ai_s2, hwu_pkg::Q_ONE);
			ao1_s3   <= hwu_pkg::qsub(ao_s2, hwu_pkg::Q_ONE);
			oneao_s3 <= hwu_pkg::qsub(hwu_pkg::Q_ONE, ao_s2);
			h_s3     <= h_s2;
			nh_s3    <= hwu_pkg::qneg(h_s2);
			pr_s3    <= pr_s2;
			po_s3    <= po_s2;
			old_s3   <= old_s2;
			inh_s3   <= inh_s2;
		end
		if (rdy[4]) begin
			it_s4 <= it4_d;
		end
		// Chained multiplies: product stage then round stage
		if (rdy[5]) begin
			p_s5 <= hwu_pkg::mul_step(it_s4);
		end
		if (rdy[6]) begin
			it_s6 <= hwu_pkg::round_step(p_s5);
		end
		if (rdy[7]) begin
			p_s7 <= hwu_pkg::mul_step(it_s6);
		end
		if (rdy[8]) begin
			it_s8 <= hwu_pkg::round_step(p_s7);
		end
		if (rdy[9]) begin
			p_s9 <= hwu_pkg::mul_step(it_s8);
		end
		if (rdy[10]) begin
			it_s10 <= hwu_pkg::round_step(p_s9);
		end
		if (rdy[11]) begin
			p_s11 <= hwu_pkg::mul_step(it_s10);
		end
		if (rdy[12]) begin
			it_s12 <= hwu_pkg::round_step(p_s11);
		end
		// Sum the terms left to right
		if (rdy[13]) begin
			d1_s13  <= hwu_pkg::qadd(it_s12.lane[0].acc, it_s12.lane[1].acc);
			t3_s13  <= it_s12.lane[2].acc;
			w_s13   <= it_s12.w;
			old_s13 <= it_s12.old_sel;
			inh_s13 <= it_s12.inh;
		end
		if (rdy[14]) begin
			d_s14   <= hwu_pkg::qadd(d1_s13, t3_s13);
			w_s14   <= w_s13;
			old_s14 <= old_s13;
			inh_s14 <= inh_s13;
		end
		if (rdy[15]) begin
			sum_s15 <= hwu_pkg::qadd(w_s14, d_s14);
			old_s15 <= old_s14;
			inh_s15 <= inh_s14;
		end
		if (rdy[16]) begin
			res_s16 <= res_d;
		end
	end

endmodule

// ===== hw/rtl/hwu_checker.sv =====
// ----------------------------------------------------------------------------
// hwu_checker: port-level checks for the Hebbian weight update core
// Watches the handshakes of the core and the backpressure it shows.
// ----------------------------------------------------------------------------
module hwu_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input hwu_pkg::q_t  new_weight
);

	// Hold a stalled result and its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_weight))
		else $error("stalled result dropped or changed");

	// Reset empties the pipeline
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result shown during reset");

	// A draining output lets every stage advance
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// An empty output stage never backs up the input
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

endmodule

bind hebbian_weight_update_core hwu_checker u_hwu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.new_weight (new_weight)
);
